>>> hw/rtl/voxel_face_mesher_with_ao_assert.svh
// Assertion macros used by the checker file.
`ifndef VOXEL_FACE_MESHER_WITH_AO_ASSERT_SVH
`define VOXEL_FACE_MESHER_WITH_AO_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define VFM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vfm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define VFM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vfm assertion failed");

`endif

>>> hw/rtl/vfm_pkg.sv
package vfm_pkg;

  // Field widths
  localparam int POS_W   = 4;
  localparam int MAT_W   = 8;
  localparam int NB_W    = 27;
  localparam int COORD_W = 5;
  localparam int LVL_W   = 8;
  localparam int FACE_W  = 3;
  localparam int STR_W   = 7;
  localparam int OCC_W   = 2;
  localparam int DARK_W  = 9;
  localparam int FACES   = 6;
  localparam int VERT_W  = 2;

  // Stream data widths, padded to whole bytes
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 56;

  localparam logic [7:0]        CHUNK_EDGE     = 8'd16;
  localparam logic [STR_W-1:0]  STRENGTH_RESET = 7'd60;
  localparam logic [LVL_W-1:0]  FULL_LEVEL     = 8'd255;
  localparam logic [OCC_W-1:0]  BOTH_SIDES_OCC = 2'd3;
  localparam int                CENTRE_BIT     = 13;

  // Face codes
  localparam logic [FACE_W-1:0] FACE_XP = 3'd0;
  localparam logic [FACE_W-1:0] FACE_XN = 3'd1;
  localparam logic [FACE_W-1:0] FACE_YP = 3'd2;
  localparam logic [FACE_W-1:0] FACE_YN = 3'd3;
  localparam logic [FACE_W-1:0] FACE_ZP = 3'd4;
  localparam logic [FACE_W-1:0] FACE_ZN = 3'd5;

  typedef struct packed {
    logic [LVL_W-1:0] d;
    logic [LVL_W-1:0] c;
    logic [LVL_W-1:0] b;
    logic [LVL_W-1:0] a;
  } shade_t;

  // Faces whose direct neighbor is empty, bit f for face code f
  function automatic logic [FACES-1:0] exposed(input logic [NB_W-1:0] nb);
    return {!nb[4], !nb[22], !nb[10], !nb[16], !nb[12], !nb[14]};
  endfunction

  // Occluder bits per level, level k at [3k+2:3k] as {corner, side, side}
  function automatic logic [11:0] occ_bits(input logic [FACE_W-1:0] face,
                                           input logic [NB_W-1:0] nb);
    logic [11:0] r;
    case (face)
      FACE_XP: r = {nb[8], nb[5], nb[17], nb[2], nb[5], nb[11],
                    nb[26], nb[23], nb[17], nb[20], nb[23], nb[11]};
      FACE_XN: r = {nb[24], nb[21], nb[15], nb[18], nb[21], nb[9],
                    nb[6], nb[3], nb[15], nb[0], nb[3], nb[9]};
      FACE_YP: r = {nb[24], nb[25], nb[15], nb[6], nb[7], nb[15],
                    nb[26], nb[25], nb[17], nb[8], nb[7], nb[17]};
      FACE_YN: r = {nb[20], nb[19], nb[11], nb[2], nb[1], nb[11],
                    nb[18], nb[19], nb[9], nb[0], nb[1], nb[9]};
      FACE_ZP: r = {nb[26], nb[25], nb[23], nb[20], nb[19], nb[23],
                    nb[24], nb[25], nb[21], nb[18], nb[19], nb[21]};
      FACE_ZN: r = {nb[6], nb[7], nb[3], nb[0], nb[1], nb[3],
                    nb[8], nb[7], nb[5], nb[2], nb[1], nb[5]};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Corner offset of a vertex as {z, y, x}, in winding order
  function automatic logic [2:0] vert_off(input logic [FACE_W-1:0] face,
                                          input logic [VERT_W-1:0] idx);
    logic [11:0] row;
    case (face)
      FACE_XP: row = {3'b111, 3'b011, 3'b001, 3'b101};
      FACE_XN: row = {3'b010, 3'b110, 3'b100, 3'b000};
      FACE_YP: row = {3'b111, 3'b110, 3'b010, 3'b011};
      FACE_YN: row = {3'b100, 3'b101, 3'b001, 3'b000};
      FACE_ZP: row = {3'b110, 3'b111, 3'b101, 3'b100};
      FACE_ZN: row = {3'b011, 3'b010, 3'b000, 3'b001};
      default: row = '0;
    endcase
    return row[idx*3 +: 3];
  endfunction

  // Saturate a position to the last cell of the chunk
  function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] p);
    logic [7:0] last;
    last = CHUNK_EDGE - 8'd1;
    if ({4'd0, p} >= CHUNK_EDGE) return last[POS_W-1:0];
    return p;
  endfunction

endpackage

>>> hw/rtl/vfm_shade.sv
module vfm_shade (
  input  logic [vfm_pkg::FACE_W-1:0] face,
  input  logic [vfm_pkg::NB_W-1:0]   nb,
  input  logic [vfm_pkg::STR_W-1:0]  strength,
  output vfm_pkg::shade_t            shade
);
  import vfm_pkg::*;

  logic [11:0]      occ;
  logic [LVL_W-1:0] lvl [4];

  assign occ = occ_bits(face, nb);

  // Count occluders per corner, scale and saturate at black
  always_comb begin
    logic [OCC_W-1:0]  cnt;
    logic [DARK_W-1:0] dark;
    logic [DARK_W-1:0] diff;
    for (int k = 0; k < 4; k++) begin
      if (occ[3*k] && occ[3*k+1]) begin
        cnt = BOTH_SIDES_OCC;
      end else begin
        cnt = OCC_W'({1'b0, occ[3*k]} + {1'b0, occ[3*k+1]} + {1'b0, occ[3*k+2]});
      end
      dark = {{(DARK_W-OCC_W){1'b0}}, cnt} * {{(DARK_W-STR_W){1'b0}}, strength};
      diff = {1'b0, FULL_LEVEL} - dark;
      lvl[k] = (dark >= {1'b0, FULL_LEVEL}) ? '0 : diff[LVL_W-1:0];
    end
  end

  assign shade.a = lvl[0];
  assign shade.b = lvl[1];
  assign shade.c = lvl[2];
  assign shade.d = lvl[3];

endmodule

>>> hw/rtl/voxel_face_mesher_with_ao.sv
// An accepted voxel is loaded into the voxel registers; each of its vertices then passes
// through the single vertex output register. Throughput: one vertex per cycle while the
// output is not stalled; a voxel with exposed faces holds the input until its last
// vertex is taken. Voxels that emit nothing are taken one per cycle.
// Reset (rst, synchronous): output empty, no voxel in flight, strength 60.
module voxel_face_mesher_with_ao (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // pos_x, pos_y, pos_z, material, neighbourhood, zero pad
  input  logic [vfm_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // vert_x, vert_y, vert_z, vert_material, shade_a, shade_b, shade_c, shade_d, zero pad
  output logic [vfm_pkg::M_DATA_W-1:0] m_tdata,
  // face
  output logic [vfm_pkg::FACE_W-1:0]   m_tuser,
  output logic                         m_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vfm_pkg::STR_W-1:0]    cfg_data
);
  import vfm_pkg::*;

  logic [STR_W-1:0]   strength;

  // Voxel being expanded
  logic               busy;
  logic [POS_W-1:0]   px, py, pz;
  logic [MAT_W-1:0]   mat;
  logic [NB_W-1:0]    nb;
  logic [FACES-1:0]   mask;
  logic [VERT_W-1:0]  vcnt;

  logic [FACE_W-1:0]  cur_face;
  logic [FACES-1:0]   cur_onehot;
  logic [FACES-1:0]   rest_mask;
  logic               face_done;
  logic               item_last;
  logic               advance;
  logic               accept;
  logic [FACES-1:0]   in_mask;
  logic [2:0]         off;
  shade_t             shade;

  // Input fields
  logic [POS_W-1:0]   in_x, in_y, in_z;
  logic [MAT_W-1:0]   in_mat;
  logic [NB_W-1:0]    in_nb;

  assign in_x   = s_tdata[3:0];
  assign in_y   = s_tdata[7:4];
  assign in_z   = s_tdata[11:8];
  assign in_mat = s_tdata[19:12];
  assign in_nb  = s_tdata[46:20];
  assign in_mask = in_nb[CENTRE_BIT] ? exposed(in_nb) : '0;

  // Pick the lowest remaining face
  always_comb begin
    cur_face = FACE_XP;
    for (int i = FACES - 1; i >= 0; i--) begin
      if (mask[i]) cur_face = FACE_W'(i);
    end
  end

  assign cur_onehot = FACES'(1) << cur_face;
  assign rest_mask  = mask & ~cur_onehot;
  assign face_done  = (vcnt == '1);
  assign item_last  = face_done && (rest_mask == '0);

  assign advance   = busy && (!m_tvalid || m_tready);
  assign s_tready  = !busy || (advance && item_last);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  vfm_shade u_shade (
    .face     (cur_face),
    .nb       (nb),
    .strength (strength),
    .shade    (shade)
  );

  assign off = vert_off(cur_face, vcnt);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      strength <= STRENGTH_RESET;
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) strength <= cfg_data;
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (accept) begin
        busy <= (in_mask != '0);
      end else if (advance && item_last) begin
        busy <= 1'b0;
      end
    end
  end

  // Load a new voxel, or step through its faces and vertices
  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= clamp_pos(in_x);
      py   <= clamp_pos(in_y);
      pz   <= clamp_pos(in_z);
      mat  <= in_mat;
      nb   <= in_nb;
      mask <= in_mask;
      vcnt <= '0;
    end else if (advance) begin
      vcnt <= vcnt + VERT_W'(1);
      if (face_done) mask <= rest_mask;
    end
  end

  // Vertex output register
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tuser <= cur_face;
      m_tlast <= item_last;
      m_tdata <= {1'b0, shade.d, shade.c, shade.b, shade.a, mat,
                  {1'b0, pz} + {4'd0, off[2]},
                  {1'b0, py} + {4'd0, off[1]},
                  {1'b0, px} + {4'd0, off[0]}};
    end
  end

endmodule

>>> hw/rtl/vfm_check.sv
`include "voxel_face_mesher_with_ao_assert.svh"

module vfm_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [vfm_pkg::M_DATA_W-1:0] m_tdata,
  input logic [vfm_pkg::FACE_W-1:0]   m_tuser,
  input logic                         m_tlast
);
  import vfm_pkg::*;

  // Hold a stalled vertex unchanged
  `VFM_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // Face code stays within the six faces
  `VFM_ASSERT_NOW(a_face_range, m_tvalid, m_tuser <= FACE_ZN)

  // Vertex corners never leave the chunk plus one
  `VFM_ASSERT_NOW(a_coord_range, m_tvalid, (m_tdata[4:0] <= 5'd16) && (m_tdata[9:5] <= 5'd16) && (m_tdata[14:10] <= 5'd16))

  // Output is empty right after reset
  `VFM_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid)

endmodule

bind voxel_face_mesher_with_ao vfm_check u_check (.*);
